>>> src/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared types and constants of the two-way ranging distance core.
// ----------------------------------------------------------------------------
package dtw_pkg;

  localparam int unsigned TsW     = 32;
  localparam int unsigned IdW     = 8;
  localparam int unsigned NodeW   = 8;
  localparam int unsigned NumW    = 2 * TsW;
  localparam int unsigned DenW    = TsW + 2;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 32;

  localparam logic [IdW-1:0] FinalIdReset = IdW'(2);
  localparam logic [TsW-1:0] MptReset     = TsW'(20150972);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegFinalId = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMpt     = CfgIdxW'(1);

  // numerator and divisor handed to the divider
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             zero;
    logic [NumW-1:0]  num;
    logic [DenW-1:0]  den;
  } dtw_frac_t;

  // quotient handed to the scaler
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             zero;
    logic [NumW-1:0]  quo;
  } dtw_quot_t;

endpackage

>>> src/dtw_if.sv
// ----------------------------------------------------------------------------
// dtw_req_if, dtw_rsp_if, dtw_cfg_if
// Valid/ready channels of the ranging distance core.
// ----------------------------------------------------------------------------
interface dtw_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  message_id;
  logic [7:0]  source_node;
  logic [31:0] remote_poll_sent;
  logic [31:0] remote_reply_seen;
  logic [31:0] remote_final_sent;
  logic [31:0] local_poll_seen;
  logic [31:0] local_reply_sent;
  logic [31:0] local_final_seen;

  modport source (output valid, message_id, source_node, remote_poll_sent,
                  remote_reply_seen, remote_final_sent, local_poll_seen,
                  local_reply_sent, local_final_seen, input ready);
  modport sink (input valid, message_id, source_node, remote_poll_sent,
                remote_reply_seen, remote_final_sent, local_poll_seen,
                local_reply_sent, local_final_seen, output ready);
endinterface

interface dtw_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  node_number;
  logic [31:0] distance_q16;
  logic        zero_divisor;

  modport source (output valid, node_number, distance_q16, zero_divisor,
                  input ready);
  modport sink (input valid, node_number, distance_q16, zero_divisor,
                output ready);
endinterface

interface dtw_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/dtw_front.sv
// ----------------------------------------------------------------------------
// dtw_front
// Filter final messages, form intervals, products, |numerator| and divisor.
// ----------------------------------------------------------------------------
module dtw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [7:0]          message_id,
  input  logic [7:0]          source_node,
  input  logic [31:0]         remote_poll_sent,
  input  logic [31:0]         remote_reply_seen,
  input  logic [31:0]         remote_final_sent,
  input  logic [31:0]         local_poll_seen,
  input  logic [31:0]         local_reply_sent,
  input  logic [31:0]         local_final_seen,
  input  logic [7:0]          final_id,
  output logic                out_valid,
  output dtw_pkg::dtw_frac_t  out_frac
);
  import dtw_pkg::*;

  logic             v1, v2;
  logic [NodeW-1:0] node1, node2;
  logic [TsW-1:0]   ra, rb, da, db;
  logic [NumW-1:0]  p, q;
  logic [DenW-1:0]  den2;
  logic [NumW-1:0]  num_next;

  // stage 1: intervals, modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && (message_id == final_id);
    end
    if (adv) begin
      node1 <= source_node;
      ra    <= remote_reply_seen - remote_poll_sent;
      da    <= remote_final_sent - remote_reply_seen;
      rb    <= local_final_seen - local_reply_sent;
      db    <= local_reply_sent - local_poll_seen;
    end
  end

  // stage 2: exact products and interval sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      node2 <= node1;
      p     <= NumW'(ra) * NumW'(rb);
      q     <= NumW'(da) * NumW'(db);
      den2  <= DenW'(ra) + DenW'(rb) + DenW'(da) + DenW'(db);
    end
  end

  assign num_next = (p >= q) ? (p - q) : (q - p);

  // stage 3: magnitude of the numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
    if (adv) begin
      out_frac.node <= node2;
      out_frac.zero <= (den2 == '0);
      out_frac.num  <= num_next;
      out_frac.den  <= den2;
    end
  end

endmodule

>>> src/dtw_div.sv
// ----------------------------------------------------------------------------
// dtw_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module dtw_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  dtw_pkg::dtw_frac_t  in_frac,
  output logic                out_valid,
  output dtw_pkg::dtw_quot_t  out_quot
);
  import dtw_pkg::*;

  localparam int unsigned Stages = NumW;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             zero;
    logic [NumW-1:0]  num;
    logic [DenW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [NumW-1:0]  quo;
  } div_st_t;

  div_st_t     st  [Stages+1];
  logic        vld [Stages+1];

  // stage input from the front end
  always_comb begin
    st[0].node = in_frac.node;
    st[0].zero = in_frac.zero;
    st[0].num  = in_frac.num;
    st[0].rem  = '0;
    st[0].den  = in_frac.den;
    st[0].quo  = '0;
    vld[0]     = in_valid;
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [DenW:0] trial;
    logic          fits;

    // shift in the next numerator bit and try the subtraction
    assign trial = {st[k].rem, st[k].num[NumW-1]};
    assign fits  = (trial >= {1'b0, st[k].den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
      if (adv) begin
        st[k+1].node <= st[k].node;
        st[k+1].zero <= st[k].zero;
        st[k+1].den  <= st[k].den;
        st[k+1].num  <= {st[k].num[NumW-2:0], 1'b0};
        st[k+1].rem  <= fits ? DenW'(trial - {1'b0, st[k].den}) : DenW'(trial);
        st[k+1].quo  <= {st[k].quo[NumW-2:0], fits};
      end
    end
  end

  assign out_valid     = vld[Stages];
  assign out_quot.node = st[Stages].node;
  assign out_quot.zero = st[Stages].zero;
  assign out_quot.quo  = st[Stages].quo;

endmodule

>>> src/dtw_scale.sv
// ----------------------------------------------------------------------------
// dtw_scale
// Multiply the time of flight by metres per tick into saturated Q16.16.
// ----------------------------------------------------------------------------
module dtw_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  dtw_pkg::dtw_quot_t  in_quot,
  input  logic [31:0]         mpt,
  output logic                out_valid,
  output logic [7:0]          node_number,
  output logic [31:0]         distance_q16,
  output logic                zero_divisor
);
  import dtw_pkg::*;

  logic             va;
  logic [NodeW-1:0] node_a;
  logic             zero_a;
  logic [NumW-1:0]  hi, lo;
  logic [NumW-1:0]  sum;
  logic [TsW-1:0]   dist_next;

  // stage A: partial products of both quotient halves
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
    if (adv) begin
      node_a <= in_quot.node;
      zero_a <= in_quot.zero;
      hi     <= NumW'(in_quot.quo[NumW-1:TsW]) * NumW'(mpt);
      lo     <= NumW'(in_quot.quo[TsW-1:0]) * NumW'(mpt);
    end
  end

  // combine, drop 16 fraction bits, saturate
  assign sum = (lo >> 16) + {hi[31:0], 16'h0000};

  always_comb begin
    priority if (zero_a) begin
      dist_next = '0;
    end else if (hi[NumW-1:16] != '0) begin
      dist_next = '1;
    end else if (sum[NumW-1:TsW] != '0) begin
      dist_next = '1;
    end else begin
      dist_next = sum[TsW-1:0];
    end
  end

  // stage B: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= va;
    end
    if (adv) begin
      node_number  <= node_a;
      distance_q16 <= dist_next;
      zero_divisor <= zero_a;
    end
  end

endmodule

>>> src/ds_twr_distance_core.sv
// ----------------------------------------------------------------------------
// ds_twr_distance_core
// Double-sided two-way ranging distance from six timestamps per request.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 64 divider stages of one quotient bit each,
//   2 scaling stages, from request accept to result valid.
// Throughput: one request per cycle; the whole pipeline holds while the
//   result register is full and not taken.
// Reset: synchronous rst clears all valid bits and loads final id 2 and
//   metres per tick 20150972.
module ds_twr_distance_core (
  input logic      clk,
  input logic      rst,
  dtw_req_if.sink  req,
  dtw_rsp_if.source rsp,
  dtw_cfg_if.sink  cfg
);
  import dtw_pkg::*;

  logic [IdW-1:0] final_id;
  logic [TsW-1:0] mpt;
  logic           adv;
  logic           f_valid, d_valid;
  dtw_frac_t      f_frac;
  dtw_quot_t      d_quot;

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;
  assign cfg.ready = 1'b1;

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      final_id <= FinalIdReset;
      mpt      <= MptReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegFinalId: final_id <= cfg.data[IdW-1:0];
        RegMpt:     mpt      <= cfg.data[TsW-1:0];
        default: ;
      endcase
    end
  end

  dtw_front u_front (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .in_valid          (req.valid),
    .message_id        (req.message_id),
    .source_node       (req.source_node),
    .remote_poll_sent  (req.remote_poll_sent),
    .remote_reply_seen (req.remote_reply_seen),
    .remote_final_sent (req.remote_final_sent),
    .local_poll_seen   (req.local_poll_seen),
    .local_reply_sent  (req.local_reply_sent),
    .local_final_seen  (req.local_final_seen),
    .final_id          (final_id),
    .out_valid         (f_valid),
    .out_frac          (f_frac)
  );

  dtw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_frac   (f_frac),
    .out_valid (d_valid),
    .out_quot  (d_quot)
  );

  dtw_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (d_valid),
    .in_quot      (d_quot),
    .mpt          (mpt),
    .out_valid    (rsp.valid),
    .node_number  (rsp.node_number),
    .distance_q16 (rsp.distance_q16),
    .zero_divisor (rsp.zero_divisor)
  );

  // a zero divisor always reports zero distance
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_divisor |-> rsp.distance_q16 == '0)
    else $error("zero divisor with nonzero distance");

  // a final id write takes effect on the next edge
  a_cfg_id: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.index == RegFinalId |=> final_id == $past(cfg.data[IdW-1:0]))
    else $error("final id write lost");

  // a stalled pipeline takes no request
  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while stalled");

  // a front output flagged as zero carries a zero divisor
  a_front_zero: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_frac.zero |-> f_frac.den == '0)
    else $error("zero flag without zero divisor");

endmodule
